>>> rtl/b64e_pkg.sv
// Shared types, constants and the character encoding function of the base64 encoder.
package b64e_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int LIMIT_BITS = 24;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam logic [7:0] ERR_CHAR = 8'h00;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_PLUS = 8'h2B;
   localparam logic [7:0] ASCII_SLASH = 8'h2F;

   localparam logic [2:0] HELD_NONE = 3'd0;
   localparam logic [2:0] HELD_TWO = 3'd2;
   localparam logic [2:0] HELD_FOUR = 3'd4;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] chars;
      logic [2:0]                  cnt;
      logic                        eom;
      logic                        err;
   } job_type;

   function automatic logic [7:0] encode_char(input logic [5:0] v);
      logic [7:0] code;
      if (v < 6'd26) begin
         code = {2'b00, v} + ASCII_UPPER_A;
      end else if (v < 6'd52) begin
         code = {2'b00, v} - 8'd26 + ASCII_LOWER_A;
      end else if (v < 6'd62) begin
         code = {2'b00, v} - 8'd52 + ASCII_ZERO;
      end else if (v == 6'd62) begin
         code = ASCII_PLUS;
      end else begin
         code = ASCII_SLASH;
      end
      return code;
   endfunction

endpackage

>>> rtl/b64e_front.sv
// Front end: accepts message bytes, tracks message state and builds result jobs.
module b64e_front #(
   parameter int COUNT_BITS = b64e_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   input  logic [b64e_pkg::LIMIT_BITS-1:0] limit,
   input  logic                            queue_full,
   output logic                            push,
   output b64e_pkg::job_type               job
);

   localparam int CmpBits =
      ((COUNT_BITS > b64e_pkg::LIMIT_BITS) ? COUNT_BITS : b64e_pkg::LIMIT_BITS) + 1;

   logic [3:0]            leftover_ff, leftover_in;
   logic [2:0]            held_ff, held_in;
   logic [COUNT_BITS-1:0] chars_ff, chars_in;
   logic                  drop_ff, drop_in;

   logic                  accept;
   logic [11:0]           acc;
   logic [5:0]            grp0, grp1, flush_grp;
   logic [2:0]            nc, rem, m0, total, e;
   logic [3:0]            rem_bits;
   logic [1:0]            sum2, pad;
   logic [COUNT_BITS-1:0] chars_p1, chars_pm;
   logic                  fit0, fit1, fit_pad;
   logic                  ovf;

   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;
   assign acc = {leftover_ff, req_tdata};

   always_comb begin
      grp0 = acc[7:2];
      grp1 = acc[5:0];
      flush_grp = {acc[1:0], 4'b0000};
      nc = 3'd1;
      rem = b64e_pkg::HELD_TWO;
      rem_bits = {2'b00, acc[1:0]};
      unique case (held_ff)
         b64e_pkg::HELD_TWO: begin
            grp0 = acc[9:4];
            flush_grp = {acc[3:0], 2'b00};
            rem = b64e_pkg::HELD_FOUR;
            rem_bits = acc[3:0];
         end
         b64e_pkg::HELD_FOUR: begin
            grp0 = acc[11:6];
            nc = 3'd2;
            rem = b64e_pkg::HELD_NONE;
            rem_bits = 4'b0000;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      m0 = (nc == 3'd2 || req_tlast) ? 3'd2 : 3'd1;
      sum2 = chars_ff[1:0] + m0[1:0];
      pad = 2'b00 - sum2;
      total = req_tlast ? (m0 + {1'b0, pad}) : m0;
      chars_p1 = chars_ff + COUNT_BITS'(1);
      chars_pm = chars_ff + COUNT_BITS'(m0);
      fit0 = (CmpBits'(chars_ff) + CmpBits'(1)) <= CmpBits'(limit);
      fit1 = (CmpBits'(chars_p1) + CmpBits'(1)) <= CmpBits'(limit);
      fit_pad = (CmpBits'(chars_pm) + CmpBits'(pad)) <= CmpBits'(limit);
      priority if (!fit0) begin
         e = 3'd0;
      end else if (m0 == 3'd2 && !fit1) begin
         e = 3'd1;
      end else begin
         e = m0;
      end
      ovf = (e != m0) || (req_tlast && pad != 2'b00 && !fit_pad);
   end

   always_comb begin
      job.chars[0] = b64e_pkg::encode_char(grp0);
      job.chars[1] = (nc == 3'd2) ? b64e_pkg::encode_char(grp1)
                                  : b64e_pkg::encode_char(flush_grp);
      job.chars[2] = b64e_pkg::PAD_CHAR;
      job.chars[3] = b64e_pkg::PAD_CHAR;
      if (ovf) begin
         job.chars[e[1:0]] = b64e_pkg::ERR_CHAR;
      end
      job.cnt = ovf ? (e + 3'd1) : total;
      job.eom = ovf || req_tlast;
      job.err = ovf;
      push = accept && !drop_ff;
   end

   always_comb begin
      leftover_in = leftover_ff;
      held_in = held_ff;
      chars_in = chars_ff;
      drop_in = drop_ff;
      if (accept) begin
         priority if (drop_ff) begin
            if (req_tlast) begin
               drop_in = 1'b0;
            end
         end else if (ovf || req_tlast) begin
            leftover_in = 4'b0000;
            held_in = b64e_pkg::HELD_NONE;
            chars_in = '0;
            drop_in = ovf && !req_tlast;
         end else begin
            leftover_in = rem_bits;
            held_in = rem;
            chars_in = chars_ff + COUNT_BITS'(nc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff <= 4'b0000;
         held_ff <= b64e_pkg::HELD_NONE;
         chars_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         leftover_ff <= leftover_in;
         held_ff <= held_in;
         chars_ff <= chars_in;
         drop_ff <= drop_in;
      end
   end

endmodule

>>> rtl/b64e_queue.sv
// Job queue between the front end and the back end.
module b64e_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output b64e_pkg::job_type head_job
);

   b64e_pkg::job_type                  mem_ff [b64e_pkg::QUEUE_DEPTH];
   logic [b64e_pkg::PTR_BITS-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [b64e_pkg::FILL_BITS-1:0]     fill_ff, fill_in;

   localparam logic [b64e_pkg::PTR_BITS-1:0] LastPtr =
      b64e_pkg::PTR_BITS'(b64e_pkg::QUEUE_DEPTH - 1);

   assign full = fill_ff == b64e_pkg::FILL_BITS'(b64e_pkg::QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_job = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

>>> rtl/b64e_back.sv
// Back end: walks each job and sends its characters one beat per cycle while rsp_tready is high.
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  b64e_pkg::job_type q_job,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       eom_ff, eom_in;
   logic       err_ff, err_in;
   logic       load, tail;

   assign tail = ({1'b0, idx_ff} + 3'd1) == q_job.cnt;
   assign load = q_valid && (!valid_ff || rsp_tready);
   assign q_pop = load && tail;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = eom_ff;
   assign rsp_tuser = err_ff;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in = data_ff;
      eom_in = eom_ff;
      err_in = err_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in = q_job.chars[idx_ff];
         eom_in = tail && q_job.eom;
         err_in = tail && q_job.err;
         idx_in = tail ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      eom_ff <= eom_in;
      err_ff <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> rtl/base64_encoder.sv
// Streaming base64 encoder (standard alphabet, '=' padding) with a per-message output limit.
// Each accepted byte turns into one or two characters, and up to four on the last byte of a
// message (flush character plus '=' padding); a limit overflow ends the message with one
// error beat (tuser high, tlast high) and the rest of that message's bytes are dropped
// without output. The front end takes a byte every cycle while its two-entry job queue has
// room; the back end sends one character per cycle while rsp_tready is high, so the
// sustained rate is set by the output port: one to four characters per byte, about four
// characters per three bytes of a long message. Jobs are queued; beats are registered.
// The output limit is written on the csr port between bytes and applies from the next byte.
module base64_encoder #(
   parameter int COUNT_BITS = b64e_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // data_byte
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // char_code
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,  // overflow_error
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [b64e_pkg::LIMIT_BITS-1:0] csr_data
);

   logic [b64e_pkg::LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                            push, q_full, q_pop, q_valid;
   b64e_pkg::job_type               push_job, head_job;

   assign csr_ready = 1'b1;
   assign limit_in = (csr_valid && csr_ready) ? csr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= b64e_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   b64e_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .limit      (limit_ff),
      .queue_full (q_full),
      .push       (push),
      .job        (push_job)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("job pushed into a full queue");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_error_ends_message: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("overflow beat without end of message");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming base64 encoder and its per-message output limit.
module tb;

   localparam int WATCHDOG_CYCLES = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS = 10;
   localparam int STALL_CYCLES = 300;
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] code;
      logic       eom;
      logic       err;
   } b64_beat_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = 8'd0;  // data_byte
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [7:0]                      rsp_tdata;         // char_code
   logic                            rsp_tlast;
   logic                            rsp_tuser;         // overflow_error
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [b64e_pkg::LIMIT_BITS-1:0] csr_data = '0;

   logic [b64e_pkg::LIMIT_BITS-1:0]     char_limit;
   logic [3:0]                          spare_bits;
   logic [2:0]                          spare_count;
   logic [b64e_pkg::COUNT_BITS_DEF-1:0] sent_count;
   logic                                discarding;
   b64_beat_type                        pending_chars[$];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_cycles = 0;

   base64_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      return ALPHABET[8*(63 - int'(v)) +: 8];
   endfunction

   function automatic logic room_for(input int extra);
      return ({8'd0, sent_count} + 32'(extra)) <= {8'd0, char_limit};
   endfunction

   task automatic clear_msg();
      spare_bits = 4'd0;
      spare_count = b64e_pkg::HELD_NONE;
      sent_count = '0;
      discarding = 1'b0;
   endtask

   task automatic push_char(input logic [7:0] code);
      pending_chars.push_back(b64_beat_type'{code: code, eom: 1'b0, err: 1'b0});
      sent_count = sent_count + 1'b1;
   endtask

   task automatic push_overflow(input logic last);
      pending_chars.push_back(b64_beat_type'{code: b64e_pkg::ERR_CHAR, eom: 1'b1, err: 1'b1});
      clear_msg();
      discarding = !last;
   endtask

   task automatic predict_chars(input logic [7:0] b, input logic last);
      logic [11:0]  acc;
      int           bits;
      int           pad;
      int           base;
      b64_beat_type tail;
      base = pending_chars.size();
      if (discarding) begin
         if (last) clear_msg();
         return;
      end
      bits = int'(spare_count) % 6;
      acc = {spare_bits & 4'((1 << bits) - 1), b};
      bits += 8;
      while (bits >= 6) begin
         bits -= 6;
         if (!room_for(1)) begin
            push_overflow(last);
            return;
         end
         push_char(b64_char(6'(acc >> bits)));
      end
      spare_bits = 4'(acc & 12'((1 << bits) - 1));
      spare_count = 3'(bits);
      if (!last) return;
      if (bits > 0) begin
         if (!room_for(1)) begin
            push_overflow(1'b1);
            return;
         end
         push_char(b64_char(6'(acc << (6 - bits))));
      end
      pad = (4 - int'(sent_count[1:0])) % 4;
      if (pad > 0 && !room_for(pad)) begin
         push_overflow(1'b1);
         return;
      end
      repeat (pad) push_char(b64e_pkg::PAD_CHAR);
      if (pending_chars.size() > base) begin
         tail = pending_chars.pop_back();
         tail.eom = 1'b1;
         pending_chars.push_back(tail);
      end
      clear_msg();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_chars(b, last);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [b64e_pkg::LIMIT_BITS-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      char_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_alphabet_and_padding();
      write_limit(b64e_pkg::LIMIT_RESET);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
   endtask

   task automatic test_limit_overflow();
      write_limit('0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b1);
      write_limit(24'd3);
      send_byte(8'h12, 1'b1);
      write_limit(24'd4);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b1);
      write_limit(24'd5);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b0);
      send_byte(8'h64, 1'b1);
      write_limit(b64e_pkg::LIMIT_RESET);
      send_byte(8'h10, 1'b0);
      write_limit(24'd1);
      send_byte(8'h20, 1'b1);
   endtask

   task automatic test_random_messages(input int budget);
      int sent;
      int len;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(5))
               0: begin
                  write_limit('0);
               end
               1: begin
                  write_limit(b64e_pkg::LIMIT_RESET);
               end
               2, 3: begin
                  write_limit(24'($urandom_range(1, 12)));
               end
               4: begin
                  write_limit(24'($urandom_range(13, 40)));
               end
               default: begin
                  write_limit(24'($urandom));
               end
            endcase
         end
         len = ($urandom_range(4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         send_message(len);
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      write_limit(b64e_pkg::LIMIT_RESET);
      stall_cycles = STALL_CYCLES;
      send_message(24);
   endtask

   always @(negedge clock) begin
      if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_chars
      b64_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: unexpected beat data=%h last=%b user=%b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== want.code || rsp_tlast !== want.eom || rsp_tuser !== want.err) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: expected data=%h last=%b user=%b, got data=%h last=%b user=%b",
                           $time, want.code, want.eom, want.err,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      char_limit = b64e_pkg::LIMIT_RESET;
      clear_msg();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 6;
      rsp_idle_pct = 68;
      test_alphabet_and_padding();
      test_limit_overflow();
      test_random_messages(70);

      req_idle_pct = 68;
      rsp_idle_pct = 6;
      test_random_messages(70);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_backpressure();
      test_random_messages(40);

      wait_idle();
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> base64_encoder.f
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_encoder.sv
bench/tb.sv
